@@ hdl/raw_string_literal_scanner_defines.svh @@
// ----------------------------------------------------------------------------
// raw_string_literal_scanner_defines.svh
// Assertion macros shared by the scanner's checker.
// ----------------------------------------------------------------------------
`ifndef RAW_STRING_LITERAL_SCANNER_DEFINES_SVH
`define RAW_STRING_LITERAL_SCANNER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define RSL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define RSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/rsl_pkg.sv @@
// ----------------------------------------------------------------------------
// rsl_pkg
// Types and constants shared by the raw string literal scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsl_pkg;

  localparam int CpW    = 21;
  localparam int KindW  = 3;
  localparam int EventW = 3;

  localparam logic [CpW-1:0] CpQuote     = 21'h00022;
  localparam logic [CpW-1:0] CpBackslash = 21'h0005C;
  localparam logic [CpW-1:0] CpNewline   = 21'h0000A;
  localparam logic [CpW-1:0] CpLowerU    = 21'h00075;
  localparam logic [CpW-1:0] CpUpperU    = 21'h00055;
  localparam logic [CpW-1:0] CpUpperL    = 21'h0004C;
  localparam logic [CpW-1:0] CpEight     = 21'h00038;

  localparam logic [KindW-1:0] KindPlain = 3'd0;
  localparam logic [KindW-1:0] KindUtf8  = 3'd1;
  localparam logic [KindW-1:0] KindUtf16 = 3'd2;
  localparam logic [KindW-1:0] KindUtf32 = 3'd3;
  localparam logic [KindW-1:0] KindWide  = 3'd4;

  localparam logic [EventW-1:0] EvChar    = 3'd0;
  localparam logic [EventW-1:0] EvEnd     = 3'd1;
  localparam logic [EventW-1:0] EvNoMatch = 3'd2;
  localparam logic [EventW-1:0] EvNewline = 3'd3;
  localparam logic [EventW-1:0] EvUnterm  = 3'd4;

  // Scan phase, one-hot.
  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_U    = 7'b0000010,
    PH_U8   = 7'b0000100,
    PH_BIGU = 7'b0001000,
    PH_L    = 7'b0010000,
    PH_BODY = 7'b0100000,
    PH_ESC  = 7'b1000000
  } phase_t;

  // Decision for one item: the result it gives, if any, and the new state.
  typedef struct packed {
    logic              has_res;
    logic [CpW-1:0]    char_val;
    logic [KindW-1:0]  kind_val;
    logic [EventW-1:0] event_val;
    logic              last;
    phase_t            phase_next;
    logic [KindW-1:0]  kind_next;
  } step_t;

endpackage

`default_nettype wire

@@ hdl/rsl_step.sv @@
// ----------------------------------------------------------------------------
// rsl_step
// Decides the result and next scan state for one code point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsl_step (
  input  wire rsl_pkg::phase_t              phase,
  input  wire logic [rsl_pkg::KindW-1:0]    kind_held,
  input  wire logic [rsl_pkg::CpW-1:0]      cp,
  input  wire logic                         eoi,
  output rsl_pkg::step_t                    step
);

  // Helpers for the result fields of the step.
  always_comb begin
    step            = '0;
    step.phase_next = phase;
    step.kind_next  = kind_held;
    step.kind_val   = kind_held;
    step.event_val  = rsl_pkg::EvChar;

    case (phase)
      rsl_pkg::PH_U: begin
        if (!eoi && cp == rsl_pkg::CpEight) begin
          step.phase_next = rsl_pkg::PH_U8;
        end else if (!eoi && cp == rsl_pkg::CpQuote) begin
          step.phase_next = rsl_pkg::PH_BODY;
          step.kind_next  = rsl_pkg::KindUtf16;
        end else begin
          step.has_res    = 1'b1;
          step.kind_val   = rsl_pkg::KindPlain;
          step.event_val  = rsl_pkg::EvNoMatch;
          step.last       = 1'b1;
          step.phase_next = rsl_pkg::PH_IDLE;
          step.kind_next  = rsl_pkg::KindPlain;
        end
      end
      rsl_pkg::PH_U8, rsl_pkg::PH_BIGU, rsl_pkg::PH_L: begin
        if (!eoi && cp == rsl_pkg::CpQuote) begin
          step.phase_next = rsl_pkg::PH_BODY;
          if (phase == rsl_pkg::PH_U8) begin
            step.kind_next = rsl_pkg::KindUtf8;
          end else if (phase == rsl_pkg::PH_BIGU) begin
            step.kind_next = rsl_pkg::KindUtf32;
          end else begin
            step.kind_next = rsl_pkg::KindWide;
          end
        end else begin
          step.has_res    = 1'b1;
          step.kind_val   = rsl_pkg::KindPlain;
          step.event_val  = rsl_pkg::EvNoMatch;
          step.last       = 1'b1;
          step.phase_next = rsl_pkg::PH_IDLE;
          step.kind_next  = rsl_pkg::KindPlain;
        end
      end
      rsl_pkg::PH_BODY: begin
        step.has_res = 1'b1;
        if (eoi) begin
          step.event_val  = rsl_pkg::EvUnterm;
          step.last       = 1'b1;
          step.phase_next = rsl_pkg::PH_IDLE;
        end else if (cp == rsl_pkg::CpQuote) begin
          step.event_val  = rsl_pkg::EvEnd;
          step.last       = 1'b1;
          step.phase_next = rsl_pkg::PH_IDLE;
        end else if (cp == rsl_pkg::CpNewline) begin
          step.event_val  = rsl_pkg::EvNewline;
          step.last       = 1'b1;
          step.phase_next = rsl_pkg::PH_IDLE;
        end else begin
          step.char_val = cp;
          if (cp == rsl_pkg::CpBackslash) begin
            step.phase_next = rsl_pkg::PH_ESC;
          end
        end
      end
      rsl_pkg::PH_ESC: begin
        step.has_res = 1'b1;
        if (eoi) begin
          step.event_val  = rsl_pkg::EvUnterm;
          step.last       = 1'b1;
          step.phase_next = rsl_pkg::PH_IDLE;
        end else begin
          step.char_val   = cp;
          step.phase_next = rsl_pkg::PH_BODY;
        end
      end
      default: begin
        // Idle: look for the start of a prefix.
        if (!eoi && cp == rsl_pkg::CpQuote) begin
          step.phase_next = rsl_pkg::PH_BODY;
          step.kind_next  = rsl_pkg::KindPlain;
        end else if (!eoi && cp == rsl_pkg::CpLowerU) begin
          step.phase_next = rsl_pkg::PH_U;
        end else if (!eoi && cp == rsl_pkg::CpUpperU) begin
          step.phase_next = rsl_pkg::PH_BIGU;
        end else if (!eoi && cp == rsl_pkg::CpUpperL) begin
          step.phase_next = rsl_pkg::PH_L;
        end else begin
          step.has_res    = 1'b1;
          step.kind_val   = rsl_pkg::KindPlain;
          step.event_val  = rsl_pkg::EvNoMatch;
          step.last       = 1'b1;
          step.phase_next = rsl_pkg::PH_IDLE;
          step.kind_next  = rsl_pkg::KindPlain;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/raw_string_literal_scanner.sv @@
// ----------------------------------------------------------------------------
// raw_string_literal_scanner
// Streams a C string literal one code point per item, prefix through close.
// ----------------------------------------------------------------------------
// The scanner takes one code point per item and sustains one item per clock
// while no result waits on a stalled output. An accepted item lands in an
// input register; the next cycle a small decoder looks at it together with
// the scan phase and literal kind and, once any result it yields has a place
// to go, updates both and loads the result register. The figure of one item
// per cycle is set by the phase register, which must settle one code point
// before the next may be decoded. Prefix characters (u, u8, U, L and the
// opening quote) yield no result. A mismatching prefix yields a no-match
// result and the scanner returns to idle; the offending code point is
// consumed with it, so the source should rewind and resend it. Inside the
// literal each code point, including a backslash and whatever follows it, is
// passed on as content. The closing quote, a bare newline or end of input ends
// the literal with token_last set. A stalled result register holds its item;
// the input register then accepts only while empty or while its item yields
// no result, and items without a result pass regardless of the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module raw_string_literal_scanner (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [rsl_pkg::CpW-1:0]       code_point,
  input  wire logic                          end_of_input,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [rsl_pkg::CpW-1:0]       char_out,
  output      logic [rsl_pkg::KindW-1:0]     literal_kind,
  output      logic [rsl_pkg::EventW-1:0]    event_res,
  output      logic                          token_last
);

  // Input register.
  logic                        in_full;
  logic [rsl_pkg::CpW-1:0]     in_cp;
  logic                        in_eoi;

  // Scan state.
  rsl_pkg::phase_t             phase;
  logic [rsl_pkg::KindW-1:0]   kind_held;

  // Result register.
  logic                        out_full;

  rsl_pkg::step_t              step;
  logic                        advance;

  rsl_step u_step (
    .phase     (phase),
    .kind_held (kind_held),
    .cp        (in_cp),
    .eoi       (in_eoi),
    .step      (step)
  );

  // The held item is decoded when its result, if any, has a place to go.
  assign advance   = in_full && (!step.has_res || !out_full || out_ready);
  assign in_ready  = !in_full || advance;
  assign out_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_full  <= 1'b0;
      phase     <= rsl_pkg::PH_IDLE;
      kind_held <= rsl_pkg::KindPlain;
    end else begin
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end

      if (advance && step.has_res) begin
        out_full <= 1'b1;
      end else if (out_ready) begin
        out_full <= 1'b0;
      end

      if (advance) begin
        phase     <= step.phase_next;
        kind_held <= step.kind_next;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cp  <= code_point;
      in_eoi <= end_of_input;
    end
    if (advance && step.has_res) begin
      char_out     <= step.char_val;
      literal_kind <= step.kind_val;
      event_res    <= step.event_val;
      token_last   <= step.last;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rsl_checker.sv @@
// ----------------------------------------------------------------------------
// rsl_checker
// Port-level assertions for the raw string literal scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "raw_string_literal_scanner_defines.svh"

module rsl_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [rsl_pkg::CpW-1:0]       code_point,
  input wire logic                          end_of_input,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [rsl_pkg::CpW-1:0]       char_out,
  input wire logic [rsl_pkg::KindW-1:0]     literal_kind,
  input wire logic [rsl_pkg::EventW-1:0]    event_res,
  input wire logic                          token_last
);

  // An item waiting at the input stays put.
  `RSL_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
    in_valid && $stable(code_point) && $stable(end_of_input), "item changed while stalled")

  // A result waiting for the consumer stays put.
  `RSL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(char_out) && $stable(literal_kind) &&
    $stable(event_res) && $stable(token_last), "result changed while stalled")

  // Only content results leave the literal open.
  `RSL_ASSERT_IMPL(a_last_matches_event, out_valid,
    token_last == (event_res != rsl_pkg::EvChar), "token_last disagrees with event")

  // A failed prefix carries no kind and no character.
  `RSL_ASSERT_IMPL(a_nomatch_clean, out_valid && event_res == rsl_pkg::EvNoMatch,
    literal_kind == rsl_pkg::KindPlain && char_out == '0, "no-match result not clean")

  // Terminal events carry no character.
  `RSL_ASSERT_IMPL(a_terminal_no_char, out_valid && event_res != rsl_pkg::EvChar,
    char_out == '0, "terminal result carries a character")

endmodule

bind raw_string_literal_scanner rsl_checker u_rsl_checker (.*);

`default_nettype wire
